@@ hw/rtl/sfc_pkg.sv @@
// sfc_pkg: shared constants, framing codes and the structs that link the
// front end, the command queue and the emitter of serial_frame_collector.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sfc_pkg;

   localparam int BYTE_W           = 8;
   localparam int LEN_W            = 6;   // frame_length width, also store address width
   localparam int MODE_W           = 2;
   localparam int BUFFER_DEPTH_DEF = 64;
   localparam int RAW_UNIT_DEF     = 32;
   localparam int QUEUE_DEPTH      = 2;

   // framing_mode codes
   localparam logic [MODE_W-1:0] MODE_SLIP = 2'd0;
   localparam logic [MODE_W-1:0] MODE_HEX  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RAW  = 2'd2;

   localparam logic [BYTE_W-1:0] END_BYTE = 8'hC0;
   localparam logic [BYTE_W-1:0] CR_BYTE  = 8'h0D;

   // one completed frame handed from front to emitter
   typedef struct packed {
      logic [LEN_W-1:0] len;
   } frame_cmd_type;

   // frame store write, front to emitter
   typedef struct packed {
      logic              en;
      logic [LEN_W-1:0]  addr;
      logic [BYTE_W-1:0] data;
   } store_wr_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_status_type;

   function automatic logic is_hex_digit(input logic [BYTE_W-1:0] b);
      return b inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]};
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/sfc_front.sv @@
// sfc_front: accepts bytes, holds fill count and framing mode, writes the
// frame store and pushes a command for each completed frame.
// Depends on sfc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sfc_front #(
   parameter int BUFFER_DEPTH   = sfc_pkg::BUFFER_DEPTH_DEF,
   parameter int RAW_UNIT_BYTES = sfc_pkg::RAW_UNIT_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [sfc_pkg::BYTE_W-1:0]    req_rx_byte,
   input  wire logic                          csr_wr_en,
   input  wire logic [sfc_pkg::MODE_W-1:0]    csr_wr_data,
   input  wire logic                          busy,
   output sfc_pkg::store_wr_type              store_wr,
   output logic                               push_valid,
   output sfc_pkg::frame_cmd_type             push_cmd
);

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int NW = sfc_pkg::LEN_W + 1;

   logic [AW-1:0]              fill_ff, fill_in;
   logic [sfc_pkg::MODE_W-1:0] mode_ff;
   logic                       accept;
   logic [NW-1:0]              next_cnt;
   logic                       full;

   assign req_stall = busy;
   assign accept    = req_valid && !busy;
   assign next_cnt  = NW'(fill_ff) + NW'(1);
   assign full      = next_cnt >= NW'(BUFFER_DEPTH);

   assign store_wr.en   = accept;
   assign store_wr.addr = sfc_pkg::LEN_W'(fill_ff);
   assign store_wr.data = req_rx_byte;

   always_comb begin
      fill_in      = fill_ff;
      push_valid   = 1'b0;
      push_cmd.len = '0;
      if (accept) begin
         if (full) begin
            fill_in = '0;   // store full: partial frame dropped
         end else begin
            fill_in = next_cnt[AW-1:0];
            case (mode_ff)
               sfc_pkg::MODE_SLIP: begin
                  if (req_rx_byte == sfc_pkg::END_BYTE) begin
                     fill_in      = '0;
                     push_valid   = (fill_ff != '0);
                     push_cmd.len = sfc_pkg::LEN_W'(fill_ff);
                  end
               end
               sfc_pkg::MODE_HEX: begin
                  if (req_rx_byte == sfc_pkg::CR_BYTE) begin
                     fill_in      = '0;
                     push_valid   = (fill_ff != '0);
                     push_cmd.len = sfc_pkg::LEN_W'(fill_ff);
                  end else if (!sfc_pkg::is_hex_digit(req_rx_byte)) begin
                     fill_in = '0;
                  end
               end
               sfc_pkg::MODE_RAW: begin
                  if (next_cnt == NW'(RAW_UNIT_BYTES)) begin
                     fill_in      = '0;
                     push_valid   = 1'b1;
                     push_cmd.len = next_cnt[sfc_pkg::LEN_W-1:0];
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         mode_ff <= sfc_pkg::MODE_SLIP;
      end else begin
         fill_ff <= fill_in;
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/sfc_queue.sv @@
// sfc_queue: short command queue between the front end and the emitter.
// Depends on sfc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sfc_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push_valid,
   input  sfc_pkg::frame_cmd_type      push_cmd,
   input  wire logic                   pop,
   output sfc_pkg::frame_cmd_type      pop_cmd,
   output sfc_pkg::queue_status_type   status
);

   localparam int PW = $clog2(sfc_pkg::QUEUE_DEPTH);
   localparam int CW = $clog2(sfc_pkg::QUEUE_DEPTH + 1);

   sfc_pkg::frame_cmd_type entry_ff [sfc_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic          do_push, do_pop;

   assign status.not_empty = (count_ff != '0);
   assign status.full      = (count_ff == CW'(sfc_pkg::QUEUE_DEPTH));
   assign do_push          = push_valid && !status.full;
   assign do_pop           = pop && status.not_empty;
   assign pop_cmd          = entry_ff[rd_ptr_ff];

   function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
      return (p == PW'(sfc_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= bump(wr_ptr_ff);
         if (do_pop)  rd_ptr_ff <= bump(rd_ptr_ff);
         if (do_push && !do_pop)      count_ff <= count_ff + CW'(1);
         else if (do_pop && !do_push) count_ff <= count_ff - CW'(1);
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/sfc_emitter.sv @@
// sfc_emitter: owns the frame store and plays a completed frame out one
// byte per cycle through a read stage and an output register.
// Depends on sfc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sfc_emitter #(
   parameter int BUFFER_DEPTH = sfc_pkg::BUFFER_DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  sfc_pkg::store_wr_type              store_wr,
   input  wire logic                          cmd_ready,
   input  sfc_pkg::frame_cmd_type             cmd,
   output logic                               pop,
   output logic                               busy,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [sfc_pkg::BYTE_W-1:0]         rsp_frame_byte,
   output logic                               rsp_frame_last,
   output logic [sfc_pkg::LEN_W-1:0]          rsp_frame_length
);

   localparam int AW = $clog2(BUFFER_DEPTH);

   typedef enum logic {ST_IDLE, ST_SEND} state_type;

   logic [sfc_pkg::BYTE_W-1:0] store_mem [BUFFER_DEPTH];

   state_type                  state_ff, state_in;
   logic [sfc_pkg::LEN_W-1:0]  idx_ff, idx_in;
   logic [sfc_pkg::LEN_W-1:0]  len_ff, len_in;
   logic                       rd_valid_ff, rd_last_ff;
   logic [sfc_pkg::LEN_W-1:0]  rd_len_ff;
   logic [sfc_pkg::BYTE_W-1:0] rd_data_ff;
   logic                       advance, issue, issue_last;

   assign advance    = !rsp_valid || !rsp_stall;
   assign pop        = (state_ff == ST_IDLE) && cmd_ready;
   assign issue      = (state_ff == ST_SEND) && advance;
   assign issue_last = (idx_ff == len_ff - sfc_pkg::LEN_W'(1));
   assign busy       = (state_ff == ST_SEND) || rd_valid_ff || rsp_valid;

   always_ff @(posedge clock) begin
      if (store_wr.en) begin
         store_mem[store_wr.addr[AW-1:0]] <= store_wr.data;
      end
      if (advance) begin
         rd_data_ff <= store_mem[idx_ff[AW-1:0]];
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      len_in   = len_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_ready) begin
               state_in = ST_SEND;
               idx_in   = '0;
               len_in   = cmd.len;
            end
         end
         ST_SEND: begin
            if (issue) begin
               idx_in = idx_ff + sfc_pkg::LEN_W'(1);
               if (issue_last) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rd_valid_ff <= 1'b0;
         rsp_valid   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (advance) begin
            rd_valid_ff <= issue;
            rsp_valid   <= rd_valid_ff;
         end
      end
      idx_ff <= idx_in;
      len_ff <= len_in;
      if (advance) begin
         rd_last_ff       <= issue_last;
         rd_len_ff        <= len_ff;
         rsp_frame_byte   <= rd_data_ff;
         rsp_frame_last   <= rd_last_ff;
         rsp_frame_length <= rd_len_ff;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/serial_frame_collector.sv @@
// serial_frame_collector: a byte accepted on req_ triggers rsp_ only when it completes a frame.
// Non-completing bytes: one per cycle while req_stall is low. A completing byte queues its
// frame, which the emitter plays through a read stage and output register, one byte per cycle
// while rsp_stall is low (single store read port); req_stall holds until the last byte leaves.
// Synchronous active-high reset clears fill count, mode (SLIP), queue and emitter; the
// frame store is not cleared. Depends on sfc_pkg, sfc_front, sfc_queue, sfc_emitter.
`timescale 1ns / 1ps
`default_nettype none
module serial_frame_collector #(
   parameter int BUFFER_DEPTH   = sfc_pkg::BUFFER_DEPTH_DEF,  // 4..64
   parameter int RAW_UNIT_BYTES = sfc_pkg::RAW_UNIT_DEF       // 1..63
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // byte input
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [sfc_pkg::BYTE_W-1:0]    req_rx_byte,
   // framing mode register
   input  wire logic                          csr_wr_en,
   input  wire logic [sfc_pkg::MODE_W-1:0]    csr_wr_data,
   // frame output
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [sfc_pkg::BYTE_W-1:0]         rsp_frame_byte,
   output logic                               rsp_frame_last,
   output logic [sfc_pkg::LEN_W-1:0]          rsp_frame_length
);

   sfc_pkg::store_wr_type     store_wr;
   sfc_pkg::frame_cmd_type    push_cmd, pop_cmd;
   sfc_pkg::queue_status_type q_status;
   logic                      push_valid, pop, emit_busy, front_busy;

   // The store is shared: the front end holds off new bytes while any frame
   // is queued or being played out, so a frame is never overwritten mid-read.
   assign front_busy = q_status.not_empty || emit_busy;

   // Front end: mode register, fill count, terminator/hex/raw classification.
   sfc_front #(
      .BUFFER_DEPTH   (BUFFER_DEPTH),
      .RAW_UNIT_BYTES (RAW_UNIT_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .busy        (front_busy),
      .store_wr    (store_wr),
      .push_valid  (push_valid),
      .push_cmd    (push_cmd)
   );

   // Completed-frame commands (length only; frames always start at entry 0).
   sfc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .pop_cmd    (pop_cmd),
      .status     (q_status)
   );

   // Back end: frame store plus read stage plus output register.
   sfc_emitter #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_emitter (
      .clock            (clock),
      .reset            (reset),
      .store_wr         (store_wr),
      .cmd_ready        (q_status.not_empty),
      .cmd              (pop_cmd),
      .pop              (pop),
      .busy             (emit_busy),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_byte   (rsp_frame_byte),
      .rsp_frame_last   (rsp_frame_last),
      .rsp_frame_length (rsp_frame_length)
   );

endmodule
`default_nettype wire

@@ hw/rtl/sfc_checker.sv @@
// sfc_checker: port-level assertions for serial_frame_collector, bound to
// the top level. Depends on sfc_pkg and serial_frame_collector.
`timescale 1ns / 1ps
`default_nettype none
module sfc_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_stall,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [sfc_pkg::BYTE_W-1:0]    rsp_frame_byte,
   input wire logic                          rsp_frame_last,
   input wire logic [sfc_pkg::LEN_W-1:0]     rsp_frame_length
);

   // a waiting result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_frame_byte)
         && $stable(rsp_frame_last) && $stable(rsp_frame_length))
      else $error("rsp item changed while stalled");

   // a frame plays out without gaps and with one length
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_frame_last |=>
         rsp_valid && rsp_frame_length == $past(rsp_frame_length))
      else $error("frame broken before its last byte");

   // input is held off while a frame is being emitted
   a_input_blocked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input accepted during frame output");

   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_frame_length != '0)
      else $error("zero frame length");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

endmodule

bind serial_frame_collector sfc_checker u_sfc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_frame_byte   (rsp_frame_byte),
   .rsp_frame_last   (rsp_frame_last),
   .rsp_frame_length (rsp_frame_length)
);
`default_nettype wire
